/* hdl/npc_pkg.sv */
`default_nettype none

package npc_pkg;

    // Search size: leading palette entries that take part (2..256).
    localparam int unsigned PALETTE_ENTRIES = 256;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COLOR_W = 3 * CHAN_W;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned SQ_W    = 2 * CHAN_W;
    // 3 * 255^2 = 195075 fits in 18 bits
    localparam int unsigned DIST_W  = SQ_W + 2;

    localparam int unsigned TREE_LEVELS = $clog2(PALETTE_ENTRIES);
    localparam int unsigned TREE_LEAVES = 1 << TREE_LEVELS;
    // distance stages (difference, sum of squares) plus compare tree
    localparam int unsigned DIST_STAGES = 2;
    localparam int unsigned STAGES      = DIST_STAGES + TREE_LEVELS;

    typedef logic [STAGES-1:0] stage_vec_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // red 23:16, green 15:8, blue 7:0
    localparam logic [COLOR_W-1:0] PALETTE_ROM [256] = '{
        24'h000000, 24'h002008, 24'h004010, 24'h006018,
        24'h008020, 24'h00a028, 24'h00c030, 24'h00e038,
        24'h080040, 24'h082048, 24'h084050, 24'h086058,
        24'h088060, 24'h08a068, 24'h08c070, 24'h08e078,
        24'h100080, 24'h102088, 24'h104090, 24'h106098,
        24'h1080a0, 24'h10a0a8, 24'h10c0b0, 24'h10e0b8,
        24'h1800c0, 24'h1820c8, 24'h1840d0, 24'h1860d8,
        24'h1880e0, 24'h18a0e8, 24'h18c0f0, 24'h18e0f8,
        24'h200400, 24'h202408, 24'h204410, 24'h206418,
        24'h208420, 24'h20a428, 24'h20c430, 24'h20e438,
        24'h280440, 24'h282448, 24'h284450, 24'h286458,
        24'h288460, 24'h28a468, 24'h28c470, 24'h28e478,
        24'h300480, 24'h302488, 24'h304490, 24'h306498,
        24'h3084a0, 24'h30a4a8, 24'h30c4b0, 24'h30e4b8,
        24'h3804c0, 24'h3824c8, 24'h3844d0, 24'h3864d8,
        24'h3884e0, 24'h38a4e8, 24'h38c4f0, 24'h38e4f8,
        24'h400800, 24'h402808, 24'h404810, 24'h406818,
        24'h408820, 24'h40a828, 24'h40c830, 24'h40e838,
        24'h480840, 24'h482848, 24'h484850, 24'h486858,
        24'h488860, 24'h48a868, 24'h48c870, 24'h48e878,
        24'h500880, 24'h502888, 24'h504890, 24'h506898,
        24'h5088a0, 24'h50a8a8, 24'h50c8b0, 24'h50e8b8,
        24'h5808c0, 24'h5828c8, 24'h5848d0, 24'h5868d8,
        24'h5888e0, 24'h58a8e8, 24'h58c8f0, 24'h58e8f8,
        24'h600c00, 24'h602c08, 24'h604c10, 24'h606c18,
        24'h608c20, 24'h60ac28, 24'h60cc30, 24'h60ec38,
        24'h680c40, 24'h682c48, 24'h684c50, 24'h686c58,
        24'h688c60, 24'h68ac68, 24'h68cc70, 24'h68ec78,
        24'h700c80, 24'h702c88, 24'h704c90, 24'h706c98,
        24'h708ca0, 24'h70aca8, 24'h70cca8, 24'h70eca8,
        24'h78ccc0, 24'h78ccc8, 24'h78ccd0, 24'h78ccd8,
        24'h78cce0, 24'h78cce8, 24'h78ccf0, 24'h78ccf8,
        24'h801000, 24'h803008, 24'h805010, 24'h807018,
        24'h809020, 24'h80a028, 24'h80c030, 24'h80e038,
        24'h881040, 24'h883048, 24'h885050, 24'h887058,
        24'h889060, 24'h88a068, 24'h88c070, 24'h88e078,
        24'h901080, 24'h903088, 24'h905090, 24'h907098,
        24'h9090a0, 24'h90a0a8, 24'h90c0b0, 24'h90e0b8,
        24'h9810c0, 24'h9830c8, 24'h9850d0, 24'h9870d8,
        24'h9890e0, 24'h98a0e8, 24'h98c0f0, 24'h98e0f8,
        24'ha01400, 24'ha03408, 24'ha05410, 24'ha07418,
        24'ha09420, 24'ha0b428, 24'ha0d430, 24'ha0f438,
        24'ha81440, 24'ha83448, 24'ha85450, 24'ha87458,
        24'ha89460, 24'ha8b468, 24'ha8d470, 24'ha8f478,
        24'hb01480, 24'hb03488, 24'hb05490, 24'hb07498,
        24'hb094a0, 24'hb0b4a8, 24'hb0d4b0, 24'hb0f4b8,
        24'hb814c0, 24'hb834c8, 24'hb854d0, 24'hb874d8,
        24'hb894e0, 24'hb8b4e8, 24'hb8d4f0, 24'hb8f4f8,
        24'hc01800, 24'hc03808, 24'hc05810, 24'hc07818,
        24'hc09820, 24'hc0b828, 24'hc0d830, 24'hc0f838,
        24'hc81840, 24'hc83848, 24'hc85850, 24'hc87858,
        24'hc89860, 24'hc8b868, 24'hc8d870, 24'hc8f878,
        24'hd01880, 24'hd03888, 24'hd05890, 24'hd07898,
        24'hd098a0, 24'hd0b8a8, 24'hd0d8b0, 24'hd0f8b8,
        24'hd818c0, 24'hd838c8, 24'hd858d0, 24'hd878d8,
        24'hd898e0, 24'hd8b8e8, 24'hd8d8f0, 24'hd8f8f8,
        24'he01c00, 24'he03c08, 24'he05c10, 24'he07c18,
        24'he09c20, 24'he0bc28, 24'he0dc30, 24'he0fc38,
        24'he81c40, 24'he83c48, 24'he85c50, 24'he87c58,
        24'he89c60, 24'he8bc68, 24'he8dc70, 24'he8fc78,
        24'hf01c80, 24'hf03c88, 24'hf05c90, 24'hf07c98,
        24'hf09ca0, 24'hf0bca8, 24'hf0dcb0, 24'hf0fcb8,
        24'hf81cc0, 24'hf83cc8, 24'hf85cd0, 24'hf87cd8,
        24'hf89ce0, 24'hf8bce8, 24'hf8dcf0, 24'hf8fcf8
    };

    // floor(log2(v)) for v >= 1, elaboration only
    function automatic int unsigned floor_log2(input int unsigned v);
        int unsigned r;
        r = 0;
        for (int unsigned k = 1; k < 32; k++) begin
            if ((v >> k) != 0) begin
                r = k;
            end
        end
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

/* hdl/npc_ctrl.sv */
`default_nettype none

module npc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output npc_pkg::stage_vec_t     load
);
    import npc_pkg::*;

    stage_vec_t valid_reg;
    stage_vec_t valid_next;

    // a stage loads when empty or when its word moves on
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next = valid_reg;
        if (load[0]) begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[STAGES-1];

    // a full stage never loads over a word its successor is not taking
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load[STAGES-2:0] & valid_reg[STAGES-2:0] & ~load[STAGES-1:1]) == '0)
        else $error("stage overwritten while successor stalled");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[STAGES-1] |-> in_ready)
        else $error("input stalled with empty output stage");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted word not captured");

endmodule

`default_nettype wire

/* hdl/npc_dist.sv */
`default_nettype none

module npc_dist (
    input  wire logic                     clk,
    input  wire logic [1:0]               load,
    input  wire logic [npc_pkg::CHAN_W-1:0] red,
    input  wire logic [npc_pkg::CHAN_W-1:0] green,
    input  wire logic [npc_pkg::CHAN_W-1:0] blue,
    output npc_pkg::dist_t                sq_dist [npc_pkg::PALETTE_ENTRIES]
);
    import npc_pkg::*;

    logic [CHAN_W-1:0] dr_reg [PALETTE_ENTRIES];
    logic [CHAN_W-1:0] dg_reg [PALETTE_ENTRIES];
    logic [CHAN_W-1:0] db_reg [PALETTE_ENTRIES];
    dist_t             dist_reg [PALETTE_ENTRIES];

    for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_entry
        localparam logic [COLOR_W-1:0] COLOR = PALETTE_ROM[i];

        logic [CHAN_W-1:0] dr_next, dg_next, db_next;
        logic [SQ_W-1:0]   sr, sg, sb;
        dist_t             dist_next;

        // stage 0: per channel absolute difference
        assign dr_next = abs_diff(red,   COLOR[3*CHAN_W-1:2*CHAN_W]);
        assign dg_next = abs_diff(green, COLOR[2*CHAN_W-1:CHAN_W]);
        assign db_next = abs_diff(blue,  COLOR[CHAN_W-1:0]);

        // stage 1: squares and their sum
        assign sr = SQ_W'(dr_reg[i]) * SQ_W'(dr_reg[i]);
        assign sg = SQ_W'(dg_reg[i]) * SQ_W'(dg_reg[i]);
        assign sb = SQ_W'(db_reg[i]) * SQ_W'(db_reg[i]);
        assign dist_next = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);

        always_ff @(posedge clk)
        begin
            if (load[0]) begin
                dr_reg[i] <= dr_next;
                dg_reg[i] <= dg_next;
                db_reg[i] <= db_next;
            end
            if (load[1]) begin
                dist_reg[i] <= dist_next;
            end
        end

        assign sq_dist[i] = dist_reg[i];
    end

endmodule

`default_nettype wire

/* hdl/npc_tree.sv */
`default_nettype none

module npc_tree (
    input  wire logic                          clk,
    input  wire logic [npc_pkg::TREE_LEVELS-1:0] load,
    input  wire npc_pkg::dist_t                sq_dist [npc_pkg::PALETTE_ENTRIES],
    output npc_pkg::idx_t                      palette_index
);
    import npc_pkg::*;

    // heap numbering: node n has children 2n and 2n+1, root is node 1
    dist_t node_dist_reg [1:TREE_LEAVES-1];
    idx_t  node_idx_reg  [1:TREE_LEAVES-1];

    for (genvar n = 1; n < TREE_LEAVES; n++) begin : g_node
        localparam int unsigned LVL = TREE_LEVELS - 1 - floor_log2(n);

        dist_t l_dist, r_dist, dist_next;
        idx_t  l_idx, r_idx, idx_next;

        if (2 * n >= TREE_LEAVES) begin : g_leaf
            localparam int unsigned LI = 2 * n - TREE_LEAVES;
            localparam int unsigned RI = LI + 1;
            // leaves past the palette size carry the largest distance
            if (LI < PALETTE_ENTRIES) begin : g_l
                assign l_dist = sq_dist[LI];
            end else begin : g_lpad
                assign l_dist = '1;
            end
            if (RI < PALETTE_ENTRIES) begin : g_r
                assign r_dist = sq_dist[RI];
            end else begin : g_rpad
                assign r_dist = '1;
            end
            assign l_idx = IDX_W'(LI);
            assign r_idx = IDX_W'(RI);
        end else begin : g_inner
            assign l_dist = node_dist_reg[2*n];
            assign l_idx  = node_idx_reg[2*n];
            assign r_dist = node_dist_reg[2*n+1];
            assign r_idx  = node_idx_reg[2*n+1];
        end

        // left holds the lower indexes, so it wins a tie
        assign dist_next = (r_dist < l_dist) ? r_dist : l_dist;
        assign idx_next  = (r_dist < l_dist) ? r_idx  : l_idx;

        always_ff @(posedge clk)
        begin
            if (load[LVL]) begin
                node_dist_reg[n] <= dist_next;
                node_idx_reg[n]  <= idx_next;
            end
        end
    end

    assign palette_index = node_idx_reg[1];

endmodule

`default_nettype wire

/* hdl/nearest_palette_color.sv */
// Nearest palette color lookup.
// Input stream: one RGB pixel per word on s_axis (red, green, blue, 8 bits each).
// Output stream: one word per pixel on m_axis carrying the 8-bit index of the
// closest entry of the fixed 256-color palette (squared Euclidean distance;
// on a tie the lowest index wins). Words leave in the order they came in.
// Throughput: one pixel per clock while m_axis takes words. Every palette entry
// has its own distance unit, and a registered compare tree with one level per
// stage reduces them. Stages in order: difference, sum of squares, then the
// compare tree, 8 tree levels for the full palette.
// Stalls: each stage holds its word while the next one is full and stalled;
// empty stages fill up, so a stall on m_axis backs up into s_axis_tready only
// once every stage holds a word. Nothing is dropped or repeated.
// Reset: rst_n (asynchronous, active low) clears the stage valid bits; words
// in flight are discarded. No other state, the palette is a ROM.
`default_nettype none

module nearest_palette_color (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // palette_index[7:0]
);
    import npc_pkg::*;

    stage_vec_t load;
    dist_t      sq_dist [PALETTE_ENTRIES];
    idx_t       palette_index;

    // handshake and stage valid bits
    npc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .load      (load)
    );

    // per-entry squared distance, two stages
    npc_dist u_dist (
        .clk     (clk),
        .load    (load[DIST_STAGES-1:0]),
        .red     (s_axis_tdata[CHAN_W-1:0]),
        .green   (s_axis_tdata[2*CHAN_W-1:CHAN_W]),
        .blue    (s_axis_tdata[3*CHAN_W-1:2*CHAN_W]),
        .sq_dist (sq_dist)
    );

    // minimum search; the root register is the output register
    npc_tree u_tree (
        .clk           (clk),
        .load          (load[STAGES-1:DIST_STAGES]),
        .sq_dist       (sq_dist),
        .palette_index (palette_index)
    );

    assign m_axis_tdata = palette_index;

endmodule

`default_nettype wire

/* tb/sv/nearest_palette_checker.sv */
`default_nettype none

// Watches both streams, predicts the palette index of every accepted pixel
// and compares each output word against the oldest prediction.
module nearest_palette_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,   // palette_index[7:0]
    output int               failures,
    output int               outstanding
);

    // red 23:16, green 15:8, blue 7:0
    localparam logic [23:0] COLOR_TABLE [256] = '{
        'h000000, 'h002008, 'h004010, 'h006018, 'h008020, 'h00a028, 'h00c030, 'h00e038,
        'h080040, 'h082048, 'h084050, 'h086058, 'h088060, 'h08a068, 'h08c070, 'h08e078,
        'h100080, 'h102088, 'h104090, 'h106098, 'h1080a0, 'h10a0a8, 'h10c0b0, 'h10e0b8,
        'h1800c0, 'h1820c8, 'h1840d0, 'h1860d8, 'h1880e0, 'h18a0e8, 'h18c0f0, 'h18e0f8,
        'h200400, 'h202408, 'h204410, 'h206418, 'h208420, 'h20a428, 'h20c430, 'h20e438,
        'h280440, 'h282448, 'h284450, 'h286458, 'h288460, 'h28a468, 'h28c470, 'h28e478,
        'h300480, 'h302488, 'h304490, 'h306498, 'h3084a0, 'h30a4a8, 'h30c4b0, 'h30e4b8,
        'h3804c0, 'h3824c8, 'h3844d0, 'h3864d8, 'h3884e0, 'h38a4e8, 'h38c4f0, 'h38e4f8,
        'h400800, 'h402808, 'h404810, 'h406818, 'h408820, 'h40a828, 'h40c830, 'h40e838,
        'h480840, 'h482848, 'h484850, 'h486858, 'h488860, 'h48a868, 'h48c870, 'h48e878,
        'h500880, 'h502888, 'h504890, 'h506898, 'h5088a0, 'h50a8a8, 'h50c8b0, 'h50e8b8,
        'h5808c0, 'h5828c8, 'h5848d0, 'h5868d8, 'h5888e0, 'h58a8e8, 'h58c8f0, 'h58e8f8,
        'h600c00, 'h602c08, 'h604c10, 'h606c18, 'h608c20, 'h60ac28, 'h60cc30, 'h60ec38,
        'h680c40, 'h682c48, 'h684c50, 'h686c58, 'h688c60, 'h68ac68, 'h68cc70, 'h68ec78,
        'h700c80, 'h702c88, 'h704c90, 'h706c98, 'h708ca0, 'h70aca8, 'h70cca8, 'h70eca8,
        'h78ccc0, 'h78ccc8, 'h78ccd0, 'h78ccd8, 'h78cce0, 'h78cce8, 'h78ccf0, 'h78ccf8,
        'h801000, 'h803008, 'h805010, 'h807018, 'h809020, 'h80a028, 'h80c030, 'h80e038,
        'h881040, 'h883048, 'h885050, 'h887058, 'h889060, 'h88a068, 'h88c070, 'h88e078,
        'h901080, 'h903088, 'h905090, 'h907098, 'h9090a0, 'h90a0a8, 'h90c0b0, 'h90e0b8,
        'h9810c0, 'h9830c8, 'h9850d0, 'h9870d8, 'h9890e0, 'h98a0e8, 'h98c0f0, 'h98e0f8,
        'ha01400, 'ha03408, 'ha05410, 'ha07418, 'ha09420, 'ha0b428, 'ha0d430, 'ha0f438,
        'ha81440, 'ha83448, 'ha85450, 'ha87458, 'ha89460, 'ha8b468, 'ha8d470, 'ha8f478,
        'hb01480, 'hb03488, 'hb05490, 'hb07498, 'hb094a0, 'hb0b4a8, 'hb0d4b0, 'hb0f4b8,
        'hb814c0, 'hb834c8, 'hb854d0, 'hb874d8, 'hb894e0, 'hb8b4e8, 'hb8d4f0, 'hb8f4f8,
        'hc01800, 'hc03808, 'hc05810, 'hc07818, 'hc09820, 'hc0b828, 'hc0d830, 'hc0f838,
        'hc81840, 'hc83848, 'hc85850, 'hc87858, 'hc89860, 'hc8b868, 'hc8d870, 'hc8f878,
        'hd01880, 'hd03888, 'hd05890, 'hd07898, 'hd098a0, 'hd0b8a8, 'hd0d8b0, 'hd0f8b8,
        'hd818c0, 'hd838c8, 'hd858d0, 'hd878d8, 'hd898e0, 'hd8b8e8, 'hd8d8f0, 'hd8f8f8,
        'he01c00, 'he03c08, 'he05c10, 'he07c18, 'he09c20, 'he0bc28, 'he0dc30, 'he0fc38,
        'he81c40, 'he83c48, 'he85c50, 'he87c58, 'he89c60, 'he8bc68, 'he8dc70, 'he8fc78,
        'hf01c80, 'hf03c88, 'hf05c90, 'hf07c98, 'hf09ca0, 'hf0bca8, 'hf0dcb0, 'hf0fcb8,
        'hf81cc0, 'hf83cc8, 'hf85cd0, 'hf87cd8, 'hf89ce0, 'hf8bce8, 'hf8dcf0, 'hf8fcf8
    };

    // entries taken into the search, clipped to the table
    localparam int SEARCH_LEN = (npc_pkg::PALETTE_ENTRIES > 256) ? 256
                              : int'(npc_pkg::PALETTE_ENTRIES);

    logic [7:0] index_queue [$];

    // scan upward, strict less-than: lowest index wins a tie
    function automatic logic [7:0] nearest_index(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
        int          dr, dg, db;
        int unsigned sq_dist;
        int unsigned best_dist;
        logic [7:0]  best;
        best      = '0;
        best_dist = 0;
        for (int i = 0; i < SEARCH_LEN; i++)
        begin
            dr      = int'(r) - int'(COLOR_TABLE[i][23:16]);
            dg      = int'(g) - int'(COLOR_TABLE[i][15:8]);
            db      = int'(b) - int'(COLOR_TABLE[i][7:0]);
            sq_dist = dr * dr + dg * dg + db * db;
            if (i == 0 || sq_dist < best_dist)
            begin
                best_dist = sq_dist;
                best      = i[7:0];
            end
        end
        return best;
    endfunction

    always @(posedge clk)
    begin : watch
        logic [7:0] want;
        int         fails;
        fails = 0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                index_queue.push_back(nearest_index(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                                    s_axis_tdata[23:16]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (index_queue.size() == 0)
                begin
                    $error("palette_index: no word pending, actual %0d", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = index_queue.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $error("palette_index expected %0d actual %0d", want, m_axis_tdata);
                        fails++;
                    end
                end
            end
        end
        failures    <= failures + fails;
        outstanding <= index_queue.size();
    end

endmodule

`default_nettype wire

/* tb/sv/nearest_palette_color_test.sv */
`default_nettype none

// Stimulus and verdict; all prediction lives in the checker.
module nearest_palette_color_test;

    localparam int RANDOM_PIXELS = 500;
    // watchdog limit, far above the slowest run (~10% gaps/stalls)
    localparam int CYCLE_LIMIT   = 200000;
    // pipeline depth is 10 for the full palette; drain margin on top
    localparam int DRAIN_CYCLES  = 40;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // red[7:0], green[15:8], blue[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // palette_index[7:0]

    int failures;
    int outstanding;
    int cycles = 0;

    // set during the stretch where neither side idles
    logic steady = 1'b0;

    nearest_palette_color dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    nearest_palette_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    always #10 clk = ~clk;

    // Output side: stall about one cycle in ten, never during the steady stretch.
    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= 10);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one pixel, given as a palette-style color (red 23:16, blue 7:0),
    // and hold it until the word is taken. tvalid is only dropped on a gap,
    // so it never falls and rises within one step.
    task automatic send_color(input logic [23:0] rgb);
        if (!steady && $urandom_range(99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted word has come out.
    // The count from the checker is registered, so look only after an edge.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    initial
    begin : stimulus
        logic [23:0] pick;
        logic [23:0] other;
        int          v;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners of the cube, primaries, exact palette hits at both
        // ends and in the crowded row around 70cca8, and equidistant pixels.
        send_color(24'h000000);
        send_color(24'hffffff);
        send_color(24'hff0000);
        send_color(24'h00ff00);
        send_color(24'h0000ff);
        send_color(24'h00ffff);
        send_color(24'hff00ff);
        send_color(24'hffff00);
        send_color(24'hf8fcf8);
        send_color(24'h002008);
        send_color(24'h70aca8);
        send_color(24'h70cca8);
        send_color(24'h70eca8);
        send_color(24'h78ccc0);
        send_color(24'h801000);
        send_color(24'h808080);
        send_color(24'h7f7f7f);
        // halfway between entries 0 and 1: tie, lower index must win
        send_color(24'h001004);
        // halfway between 70aca8 and 70cca8
        send_color(24'h70bca8);
        send_color(24'h55aa55);
        send_color(24'haa55aa);

        // hold off until the pipe is empty at least once
        drain();

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            steady = (n >= 150 && n < 300);
            if (n == 350)
            begin
                drain();
            end
            pick  = npc_pkg::PALETTE_ROM[$urandom_range(255)];
            other = npc_pkg::PALETTE_ROM[$urandom_range(255)];
            case ($urandom_range(3))
                0:
                begin
                    pick = 24'($urandom());
                end
                1:
                begin
                    // exact entry
                end
                2:
                begin
                    // entry with a small nudge per channel, clamped
                    for (int c = 0; c < 3; c++)
                    begin
                        v = int'(pick[8*c +: 8]) + int'($urandom_range(16)) - 8;
                        v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                        pick[8*c +: 8] = v[7:0];
                    end
                end
                default:
                begin
                    // midpoint of two entries, where ties tend to sit
                    for (int c = 0; c < 3; c++)
                    begin
                        v = (int'(pick[8*c +: 8]) + int'(other[8*c +: 8])) / 2;
                        pick[8*c +: 8] = v[7:0];
                    end
                end
            endcase
            send_color(pick);
        end
        steady = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* nearest_palette_color.f */
hdl/npc_pkg.sv
hdl/npc_ctrl.sv
hdl/npc_dist.sv
hdl/npc_tree.sv
hdl/nearest_palette_color.sv
tb/sv/nearest_palette_checker.sv
tb/sv/nearest_palette_color_test.sv
